/* hdl/assert_macros.svh */
// assertion macros shared by the deframer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define FDM7_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fdm7 assertion failed");

`define FDM7_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("fdm7 forbidden condition seen");

`else

`define FDM7_ASSERT(lbl, clk, rst_n, prop)

`define FDM7_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

/* hdl/fdm7_pkg.sv */
// types, codes and helper functions of the deframer
package fdm7_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 16;
    localparam int PAT_W     = 40;
    localparam int CFG_IDX_W = 8;
    localparam int EV_W      = 3;
    localparam int HDR_BYTES = 5;
    localparam int CHK_MOD   = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_TERM_PATTERN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_TYPE = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_TERM    = 2'd2,
        PH_RESYNC  = 2'd3
    } t_phase;

    typedef enum logic [EV_W-1:0] {
        EV_HDR_BYTE   = 3'd0,
        EV_HDR_OK     = 3'd1,
        EV_PAYLOAD    = 3'd2,
        EV_TERM_BYTE  = 3'd3,
        EV_FRAME_GOOD = 3'd4,
        EV_BAD_TERM   = 3'd5,
        EV_HDR_ERR    = 3'd6,
        EV_RESYNC     = 3'd7
    } t_event;

    typedef struct packed {
        logic [PAT_W-1:0]  term_pattern;
        logic [BYTE_W-1:0] control_type;
    } t_cfg;

    typedef struct packed {
        t_event            event_res;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] msg_type;
        logic [BYTE_W-1:0] msg_priority;
        logic [LEN_W-1:0]  payload_length;
        logic              is_control;
    } t_result;

    // modulo 7 of a 9-bit value by summing octal digits
    function automatic logic [2:0] mod7(input logic [8:0] v);
        logic [4:0] a;
        logic [3:0] b;
        a = 5'(v[8:6]) + 5'(v[5:3]) + 5'(v[2:0]);
        b = 4'(a[4:3]) + 4'(a[2:0]);
        mod7 = (b >= 4'(CHK_MOD)) ? 3'(b - 4'(CHK_MOD)) : b[2:0];
    endfunction

    // terminator byte expected at position pos, first byte in the top bits
    function automatic logic [BYTE_W-1:0] pattern_byte(input logic [PAT_W-1:0] pat,
                                                       input logic [2:0] pos);
        case (pos)
            3'd0:    pattern_byte = pat[39:32];
            3'd1:    pattern_byte = pat[31:24];
            3'd2:    pattern_byte = pat[23:16];
            3'd3:    pattern_byte = pat[15:8];
            3'd4:    pattern_byte = pat[7:0];
            default: pattern_byte = pat[39:32];
        endcase
    endfunction

endpackage

/* hdl/fdm7_in_if.sv */
// byte input channel
interface fdm7_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source(output valid, output rx_byte, input ready);
    modport sink(input valid, input rx_byte, output ready);
endinterface

/* hdl/fdm7_out_if.sv */
// result output channel
interface fdm7_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic [7:0]  msg_type;
    logic [7:0]  msg_priority;
    logic [15:0] payload_length;
    logic        is_control;

    modport source(output valid, output event_res, output data_byte, output msg_type,
                   output msg_priority, output payload_length, output is_control,
                   input ready);
    modport sink(input valid, input event_res, input data_byte, input msg_type,
                 input msg_priority, input payload_length, input is_control,
                 output ready);
endinterface

/* hdl/fdm7_cfg_if.sv */
// configuration write channel
interface fdm7_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [39:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

/* hdl/frame_deframer_mod7_header_top.sv */
// deframer top level: input register, deframer core, output register, config registers
//
//  channel  dir  request carries                                         handshake
//  i_in     in   rx_byte                                                 valid/ready
//  o_out    out  event_res data_byte msg_type msg_priority
//                payload_length is_control                               valid/ready
//  i_cfg    in   index data (0 terminator pattern, 1 control type)       valid/ready
//
// one byte per clock unless the output stalls; results leave through the output register
// the state update of the core sits between the input and output registers
// synchronous active-low reset clears the frame state and both config registers
// a stalled output holds its result and still lets the input register fill
// config requests are always taken, config ready is tied high
`include "assert_macros.svh"

module frame_deframer_mod7_header_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fdm7_in_if.sink         i_in,
    fdm7_out_if.source      o_out,
    fdm7_cfg_if.sink        i_cfg
);
    import fdm7_pkg::*;

    logic               r_s1_valid;
    logic [BYTE_W-1:0]  r_s1_byte;
    logic               r_out_valid;
    t_result            r_out;
    t_cfg               r_cfg;
    t_result            w_res;
    logic               w_adv;
    logic               w_step;

    assign w_adv      = !r_out_valid || o_out.ready;
    assign w_step     = r_s1_valid && w_adv;
    assign i_in.ready = !r_s1_valid || w_adv;
    assign i_cfg.ready = 1'b1;

    fdm7_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_s1_byte),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_s1_byte <= i_in.rx_byte;
        end
        if (w_step) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_TERM_PATTERN: r_cfg.term_pattern <= i_cfg.data;
                CFG_CONTROL_TYPE: r_cfg.control_type <= i_cfg.data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.event_res      = r_out.event_res;
    assign o_out.data_byte      = r_out.data_byte;
    assign o_out.msg_type       = r_out.msg_type;
    assign o_out.msg_priority   = r_out.msg_priority;
    assign o_out.payload_length = r_out.payload_length;
    assign o_out.is_control     = r_out.is_control;

    `FDM7_ASSERT(a_s1_holds_on_stall, i_clk, i_rst_n,
        (r_s1_valid && !w_adv) |=> (r_s1_valid && $stable(r_s1_byte)))
    `FDM7_ASSERT(a_out_from_s1, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(r_s1_valid))
    `FDM7_ASSERT(a_cfg_pattern_write, i_clk, i_rst_n,
        (i_cfg.valid && i_cfg.index == CFG_TERM_PATTERN) |=>
            (r_cfg.term_pattern == $past(i_cfg.data)))

endmodule

/* hdl/fdm7_core.sv */
// deframer state machine: one byte per step, result computed combinationally
`include "assert_macros.svh"

module fdm7_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [fdm7_pkg::BYTE_W-1:0]   i_byte,
    input  fdm7_pkg::t_cfg                i_cfg,
    output fdm7_pkg::t_result             o_res
);
    import fdm7_pkg::*;

    t_phase             r_phase, n_phase;
    logic [2:0]         r_hdr_cnt, n_hdr_cnt;
    logic [2:0]         r_sum, n_sum;
    logic [BYTE_W-1:0]  r_type, n_type;
    logic [BYTE_W-1:0]  r_prio, n_prio;
    logic [BYTE_W-1:0]  r_len_hi, n_len_hi;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LEN_W-1:0]   r_cnt, n_cnt;
    logic               r_term_ok, n_term_ok;
    logic [PAT_W-1:0]   r_window, n_window;

    logic [2:0]         w_sum;
    logic [BYTE_W-1:0]  w_term_byte;
    logic               w_term_hit;
    logic [PAT_W-1:0]   w_window;
    logic [2:0]         w_rs_cnt;
    logic               w_match;
    logic [LEN_W-1:0]   w_cnt_inc;
    t_event             w_event;

    assign w_sum       = mod7(9'(r_sum) + 9'(i_byte));
    assign w_term_byte = pattern_byte(i_cfg.term_pattern, r_cnt[2:0]);
    assign w_term_hit  = (i_byte == w_term_byte);
    assign w_window    = {r_window[PAT_W-BYTE_W-1:0], i_byte};
    assign w_rs_cnt    = (r_hdr_cnt < 3'(HDR_BYTES)) ? r_hdr_cnt + 3'd1 : r_hdr_cnt;
    assign w_match     = (w_rs_cnt == 3'(HDR_BYTES)) && (w_window == i_cfg.term_pattern);
    assign w_cnt_inc   = r_cnt + 16'd1;

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_sum     = r_sum;
        n_type    = r_type;
        n_prio    = r_prio;
        n_len_hi  = r_len_hi;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_term_ok = r_term_ok;
        n_window  = r_window;
        case (r_phase)
            PH_HEADER: begin
                n_sum = w_sum;
                case (r_hdr_cnt)
                    3'd0:    n_type   = i_byte;
                    3'd1:    n_prio   = i_byte;
                    3'd2:    n_len_hi = i_byte;
                    3'd3:    n_len    = {r_len_hi, i_byte};
                    default: ;
                endcase
                if (r_hdr_cnt < 3'd4) begin
                    n_hdr_cnt = r_hdr_cnt + 3'd1;
                end else if (w_sum == 3'd0) begin
                    n_hdr_cnt = 3'd0;
                    n_sum     = 3'd0;
                    n_cnt     = '0;
                    n_term_ok = 1'b1;
                    n_phase   = (r_len == '0) ? PH_TERM : PH_PAYLOAD;
                end else begin
                    n_hdr_cnt = 3'd0;
                    n_sum     = 3'd0;
                    n_window  = '0;
                    n_phase   = PH_RESYNC;
                end
            end
            PH_PAYLOAD: begin
                n_cnt = w_cnt_inc;
                if (w_cnt_inc >= r_len) begin
                    n_cnt     = '0;
                    n_term_ok = 1'b1;
                    n_phase   = PH_TERM;
                end
            end
            PH_TERM: begin
                if (!w_term_hit) begin
                    n_term_ok = 1'b0;
                end
                if (r_cnt < 16'd4) begin
                    n_cnt = w_cnt_inc;
                end else begin
                    n_phase   = PH_HEADER;
                    n_hdr_cnt = 3'd0;
                    n_sum     = 3'd0;
                    n_cnt     = '0;
                    n_term_ok = 1'b1;
                end
            end
            default: begin
                n_window  = w_window;
                n_hdr_cnt = w_rs_cnt;
                if (w_match) begin
                    n_window  = '0;
                    n_phase   = PH_HEADER;
                    n_hdr_cnt = 3'd0;
                    n_sum     = 3'd0;
                    n_cnt     = '0;
                    n_term_ok = 1'b1;
                end
            end
        endcase
    end

    // outputs
    always_comb begin
        case (r_phase)
            PH_HEADER: begin
                if (r_hdr_cnt < 3'd4) begin
                    w_event = EV_HDR_BYTE;
                end else if (w_sum == 3'd0) begin
                    w_event = EV_HDR_OK;
                end else begin
                    w_event = EV_HDR_ERR;
                end
            end
            PH_PAYLOAD: w_event = EV_PAYLOAD;
            PH_TERM: begin
                if (r_cnt < 16'd4) begin
                    w_event = EV_TERM_BYTE;
                end else if (r_term_ok && w_term_hit) begin
                    w_event = EV_FRAME_GOOD;
                end else begin
                    w_event = EV_BAD_TERM;
                end
            end
            default: w_event = w_match ? EV_RESYNC : EV_HDR_ERR;
        endcase
        o_res.event_res      = w_event;
        o_res.data_byte      = i_byte;
        o_res.msg_type       = n_type;
        o_res.msg_priority   = n_prio;
        o_res.payload_length = n_len;
        o_res.is_control     = (n_type == i_cfg.control_type);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_cnt <= 3'd0;
            r_sum     <= 3'd0;
            r_type    <= '0;
            r_prio    <= '0;
            r_len_hi  <= '0;
            r_len     <= '0;
            r_cnt     <= '0;
            r_term_ok <= 1'b1;
            r_window  <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_sum     <= n_sum;
            r_type    <= n_type;
            r_prio    <= n_prio;
            r_len_hi  <= n_len_hi;
            r_len     <= n_len;
            r_cnt     <= n_cnt;
            r_term_ok <= n_term_ok;
            r_window  <= n_window;
        end
    end

    `FDM7_ASSERT_NEVER(a_sum_range, i_clk, i_rst_n, r_sum >= 3'(CHK_MOD))
    `FDM7_ASSERT(a_hdr_count_step, i_clk, i_rst_n,
        (i_step && r_phase == PH_HEADER && r_hdr_cnt < 3'd4) |=>
            (r_hdr_cnt == $past(r_hdr_cnt) + 3'd1))
    `FDM7_ASSERT(a_frame_end_to_header, i_clk, i_rst_n,
        (i_step && (w_event == EV_FRAME_GOOD || w_event == EV_BAD_TERM ||
                    w_event == EV_RESYNC)) |=> (r_phase == PH_HEADER))
    `FDM7_ASSERT_NEVER(a_term_count_range, i_clk, i_rst_n,
        r_phase == PH_TERM && r_cnt > 16'd4)

endmodule
